/* rtl/lzmf_pkg.sv */
// Shared types and constants for the LZ77 greedy match finder.
package lzmf_pkg;

    localparam int OP_W     = 1;
    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 2;
    localparam int LEN_W    = 8;
    localparam int DIST_W   = 13;
    localparam int WINDOW_W = 13;
    localparam int COUNT_W  = 32;

    localparam logic [OP_W-1:0] OP_PUSH  = 1'b0;
    localparam logic [OP_W-1:0] OP_DRAIN = 1'b1;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 13'd4096;

    typedef enum logic [KIND_W-1:0] {
        TOKEN_LITERAL = 2'd0,
        TOKEN_MATCH   = 2'd1,
        TOKEN_END     = 2'd2
    } token_kind_t;

endpackage

/* rtl/lzmf_channels.sv */
// Handshake channels of the match finder: command, configuration and token.
interface lzmf_cmd_if;
    logic                           valid;
    logic                           ready;
    logic [lzmf_pkg::OP_W-1:0]      operation;
    logic [lzmf_pkg::BYTE_W-1:0]    data_byte;

    modport source (output valid, output operation, output data_byte, input ready);
    modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

interface lzmf_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [lzmf_pkg::WINDOW_W-1:0]  window_size;

    modport source (output valid, output window_size, input ready);
    modport sink   (input valid, input window_size, output ready);
endinterface

interface lzmf_tok_if;
    logic                           valid;
    logic                           ready;
    logic [lzmf_pkg::KIND_W-1:0]    token_kind;
    logic [lzmf_pkg::BYTE_W-1:0]    literal_byte;
    logic [lzmf_pkg::LEN_W-1:0]     match_length;
    logic [lzmf_pkg::DIST_W-1:0]    match_distance;

    modport source (output valid, output token_kind, output literal_byte,
                    output match_length, output match_distance, input ready);
    modport sink   (input valid, input token_kind, input literal_byte,
                    input match_length, input match_distance, output ready);
endinterface

/* rtl/lzmf_ram.sv */
// Generic RAM: one write port, two read ports with registered read data.
module lzmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

/* rtl/lz77_greedy_match_finder_core.sv */
// Top level: greedy LZ77 tokenizer with a brute-force, byte-serial match search.
// A token search tries each candidate distance in turn, from 1 up to the reach, comparing
// one byte pair per cycle, and stops early on a match of MAX_MATCH bytes. One item at a time.
// Reset clears the counters and sets the window to 4096; history RAM is not cleared.
// RING_DEPTH must be a power of two, which the block does not check: ring addresses are the low bits of the counters.
module lz77_greedy_match_finder_core #(
    parameter int MAX_WINDOW = 4096,
    parameter int MAX_MATCH  = 254,
    parameter int MIN_MATCH  = 2,
    parameter int RING_DEPTH = 8192
) (
    input  logic       clk,
    input  logic       rst_n,
    lzmf_cmd_if.sink   cmd,
    lzmf_cfg_if.sink   cfg,
    lzmf_tok_if.source tok
);

    localparam int LIM = (MAX_WINDOW < RING_DEPTH - MAX_MATCH) ?
                         MAX_WINDOW : (RING_DEPTH - MAX_MATCH);
    localparam int AW  = $clog2(RING_DEPTH);
    localparam int DW  = $clog2(LIM + 1);
    localparam int LW  = $clog2(MAX_MATCH + 1);
    localparam int CW  = lzmf_pkg::COUNT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_ISSUE,
        ST_SCAN,
        ST_FETCH,
        ST_LATCH,
        ST_EMIT
    } state_t;

    state_t                            state_reg, state_next;
    logic [CW-1:0]                     rcv_reg, rcv_next;
    logic [CW-1:0]                     enc_reg, enc_next;
    logic [lzmf_pkg::WINDOW_W-1:0]     window_reg, window_next;
    logic [LW-1:0]                     cap_reg, cap_next;
    logic [DW-1:0]                     reach_reg, reach_next;
    logic [DW-1:0]                     d_reg, d_next;
    logic [LW-1:0]                     k_reg, k_next;
    logic [LW-1:0]                     best_len_reg, best_len_next;
    logic [DW-1:0]                     best_dist_reg, best_dist_next;
    logic [AW-1:0]                     a_ptr_reg, a_ptr_next;
    logic [AW-1:0]                     b_ptr_reg, b_ptr_next;
    logic [lzmf_pkg::BYTE_W-1:0]       lit_reg, lit_next;
    lzmf_pkg::token_kind_t             kind_reg, kind_next;
    logic                              out_valid_reg, out_valid_next;
    lzmf_pkg::token_kind_t             out_kind_reg, out_kind_next;
    logic [lzmf_pkg::BYTE_W-1:0]       out_lit_reg, out_lit_next;
    logic [lzmf_pkg::LEN_W-1:0]        out_len_reg, out_len_next;
    logic [lzmf_pkg::DIST_W-1:0]       out_dist_reg, out_dist_next;

    logic                              ram_we;
    logic [AW-1:0]                     rd_addr_a, rd_addr_b;
    logic [lzmf_pkg::BYTE_W-1:0]       rd_data_a, rd_data_b;

    logic [AW-1:0]                     base;
    logic [CW-1:0]                     rcv_inc;
    logic [CW-1:0]                     avail;
    logic [CW-1:0]                     win_ext;
    logic [CW-1:0]                     weff;
    logic [CW-1:0]                     reach_full;
    logic                              byte_eq;
    logic [LW-1:0]                     k_inc;
    logic [LW-1:0]                     cand_len;
    logic                              better;
    logic [LW-1:0]                     best_now;

    lzmf_ram #(
        .WIDTH (lzmf_pkg::BYTE_W),
        .DEPTH (RING_DEPTH)
    ) u_history (
        .clk       (clk),
        .we        (ram_we),
        .wr_addr   (rcv_reg[AW-1:0]),
        .wr_data   (cmd.data_byte),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    assign cmd.ready          = (state_reg == ST_IDLE);
    assign cfg.ready          = 1'b1;
    assign tok.valid          = out_valid_reg;
    assign tok.token_kind     = out_kind_reg;
    assign tok.literal_byte   = out_lit_reg;
    assign tok.match_length   = out_len_reg;
    assign tok.match_distance = out_dist_reg;

    assign base       = enc_reg[AW-1:0];
    assign rcv_inc    = rcv_reg + 1'b1;
    assign avail      = rcv_reg - enc_reg;
    assign win_ext    = CW'(window_reg);
    assign weff       = (win_ext == '0) ? CW'(1) :
                        ((win_ext > CW'(LIM)) ? CW'(LIM) : win_ext);
    assign reach_full = (enc_reg < weff) ? enc_reg : weff;
    assign byte_eq    = (rd_data_a == rd_data_b);
    assign k_inc      = k_reg + 1'b1;
    assign cand_len   = byte_eq ? k_inc : k_reg;
    assign better     = (cand_len >= LW'(MIN_MATCH)) && (cand_len > best_len_reg);
    assign best_now   = better ? cand_len : best_len_reg;

    always_comb
    begin
        state_next     = state_reg;
        rcv_next       = rcv_reg;
        enc_next       = enc_reg;
        window_next    = cfg.valid ? cfg.window_size : window_reg;
        cap_next       = cap_reg;
        reach_next     = reach_reg;
        d_next         = d_reg;
        k_next         = k_reg;
        best_len_next  = best_len_reg;
        best_dist_next = best_dist_reg;
        a_ptr_next     = a_ptr_reg;
        b_ptr_next     = b_ptr_reg;
        lit_next       = lit_reg;
        kind_next      = kind_reg;
        out_valid_next = out_valid_reg && !tok.ready;
        out_kind_next  = out_kind_reg;
        out_lit_next   = out_lit_reg;
        out_len_next   = out_len_reg;
        out_dist_next  = out_dist_reg;
        ram_we         = 1'b0;
        rd_addr_a      = a_ptr_reg;
        rd_addr_b      = b_ptr_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    if (cmd.operation == lzmf_pkg::OP_PUSH)
                    begin
                        ram_we   = 1'b1;
                        rcv_next = rcv_inc;
                        if ((rcv_inc - enc_reg) >= CW'(MAX_MATCH))
                        begin
                            state_next = ST_SETUP;
                        end
                    end
                    else if (rcv_reg == enc_reg)
                    begin
                        kind_next  = lzmf_pkg::TOKEN_END;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_SETUP;
                    end
                end
            end

            ST_SETUP:
            begin
                cap_next       = (avail < CW'(MAX_MATCH)) ? LW'(avail) : LW'(MAX_MATCH);
                reach_next     = DW'(reach_full);
                d_next         = DW'(1);
                best_len_next  = '0;
                best_dist_next = '0;
                state_next     = (reach_full == '0) ? ST_FETCH : ST_ISSUE;
            end

            ST_ISSUE:
            begin
                rd_addr_a  = base - AW'(d_reg);
                rd_addr_b  = base;
                a_ptr_next = base - AW'(d_reg) + 1'b1;
                b_ptr_next = base + 1'b1;
                k_next     = '0;
                state_next = ST_SCAN;
            end

            ST_SCAN:
            begin
                if (byte_eq && (k_inc < cap_reg))
                begin
                    k_next     = k_inc;
                    a_ptr_next = a_ptr_reg + 1'b1;
                    b_ptr_next = b_ptr_reg + 1'b1;
                end
                else
                begin
                    if (better)
                    begin
                        best_len_next  = cand_len;
                        best_dist_next = d_reg;
                    end
                    if ((better && (cand_len == LW'(MAX_MATCH))) || (d_reg == reach_reg))
                    begin
                        if (best_now >= LW'(MIN_MATCH))
                        begin
                            kind_next  = lzmf_pkg::TOKEN_MATCH;
                            state_next = ST_EMIT;
                        end
                        else
                        begin
                            state_next = ST_FETCH;
                        end
                    end
                    else
                    begin
                        d_next     = d_reg + 1'b1;
                        state_next = ST_ISSUE;
                    end
                end
            end

            ST_FETCH:
            begin
                rd_addr_b  = base;
                state_next = ST_LATCH;
            end

            ST_LATCH:
            begin
                lit_next   = rd_data_b;
                kind_next  = lzmf_pkg::TOKEN_LITERAL;
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (!out_valid_reg || tok.ready)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = kind_reg;
                    state_next     = ST_IDLE;
                    case (kind_reg)
                        lzmf_pkg::TOKEN_MATCH:
                        begin
                            out_lit_next  = '0;
                            out_len_next  = lzmf_pkg::LEN_W'(best_len_reg);
                            out_dist_next = lzmf_pkg::DIST_W'(best_dist_reg);
                            enc_next      = enc_reg + CW'(best_len_reg);
                        end
                        lzmf_pkg::TOKEN_LITERAL:
                        begin
                            out_lit_next  = lit_reg;
                            out_len_next  = '0;
                            out_dist_next = '0;
                            enc_next      = enc_reg + 1'b1;
                        end
                        default:
                        begin
                            out_lit_next  = '0;
                            out_len_next  = '0;
                            out_dist_next = '0;
                            rcv_next      = '0;
                            enc_next      = '0;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rcv_reg       <= '0;
            enc_reg       <= '0;
            window_reg    <= lzmf_pkg::WINDOW_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rcv_reg       <= rcv_next;
            enc_reg       <= enc_next;
            window_reg    <= window_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cap_reg       <= cap_next;
        reach_reg     <= reach_next;
        d_reg         <= d_next;
        k_reg         <= k_next;
        best_len_reg  <= best_len_next;
        best_dist_reg <= best_dist_next;
        a_ptr_reg     <= a_ptr_next;
        b_ptr_reg     <= b_ptr_next;
        lit_reg       <= lit_next;
        kind_reg      <= kind_next;
        out_kind_reg  <= out_kind_next;
        out_lit_reg   <= out_lit_next;
        out_len_reg   <= out_len_next;
        out_dist_reg  <= out_dist_next;
    end

endmodule

/* tb/sv/tb_lz77_greedy_match_finder_core.sv */
// Self-checking testbench: byte streams through the LZ77 match finder, tokens checked in order.
module tb_lz77_greedy_match_finder_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_WINDOW = 4096;
    localparam int MAX_MATCH  = 254;
    localparam int MIN_MATCH  = 2;
    localparam int RING_DEPTH = 8192;
    localparam int WIN_LIMIT  = (RING_DEPTH - MAX_MATCH < MAX_WINDOW) ?
                                (RING_DEPTH - MAX_MATCH) : MAX_WINDOW;

    typedef struct packed {
        logic [lzmf_pkg::OP_W-1:0]   op;
        logic [lzmf_pkg::BYTE_W-1:0] data;
    } cmd_item_t;

    typedef struct packed {
        lzmf_pkg::token_kind_t       kind;
        logic [lzmf_pkg::BYTE_W-1:0] lit;
        logic [lzmf_pkg::LEN_W-1:0]  len;
        logic [lzmf_pkg::DIST_W-1:0] distance;
    } token_t;

    logic clk = 1'b0;
    logic rst_n;

    always #5 clk = ~clk;

    lzmf_cmd_if cmd_ch ();
    lzmf_cfg_if cfg_ch ();
    lzmf_tok_if tok_ch ();

    lz77_greedy_match_finder_core #(
        .MAX_WINDOW (MAX_WINDOW),
        .MAX_MATCH  (MAX_MATCH),
        .MIN_MATCH  (MIN_MATCH),
        .RING_DEPTH (RING_DEPTH)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .cfg   (cfg_ch),
        .tok   (tok_ch)
    );

    // tokenizer state mirror
    logic [lzmf_pkg::BYTE_W-1:0]   history [RING_DEPTH];
    bit [lzmf_pkg::COUNT_W-1:0]    bytes_in;
    bit [lzmf_pkg::COUNT_W-1:0]    bytes_coded;
    bit [lzmf_pkg::WINDOW_W-1:0]   window_reg;
    lzmf_pkg::token_kind_t         drain_kind;

    cmd_item_t cmd_q [$];
    token_t    pending_tokens [$];

    bit  no_idle;
    int  error_count;
    int  items_sent;
    int  lit_count;
    int  match_count;
    int  end_count;
    int  window_writes;
    int  longest_match;

    int          send_gap;
    logic        send_valid;
    cmd_item_t   next_item;
    int          recv_stall;
    logic        recv_ready;
    token_t      want;

    task automatic report_mismatch(input string msg);
        if (error_count < 40)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic find_token(output token_t t);
        bit [lzmf_pkg::COUNT_W-1:0] pos;
        bit [lzmf_pkg::COUNT_W-1:0] cap;
        bit [lzmf_pkg::COUNT_W-1:0] win;
        bit [lzmf_pkg::COUNT_W-1:0] reach;
        bit [lzmf_pkg::COUNT_W-1:0] best_len;
        bit [lzmf_pkg::COUNT_W-1:0] best_dist;
        bit [lzmf_pkg::COUNT_W-1:0] k;
        pos = bytes_coded;
        cap = bytes_in - pos;
        if (cap > MAX_MATCH)
            cap = MAX_MATCH;
        win = window_reg;
        if (win == 0)
            win = 1;
        if (win > WIN_LIMIT)
            win = WIN_LIMIT;
        reach = (pos < win) ? pos : win;
        best_len = 0;
        best_dist = 0;
        for (bit [lzmf_pkg::COUNT_W-1:0] d = 1; d <= reach; d++)
        begin
            k = 0;
            while (k < cap &&
                   history[(pos - d + k) % RING_DEPTH] == history[(pos + k) % RING_DEPTH])
                k++;
            if (k >= MIN_MATCH && k > best_len)
            begin
                best_len = k;
                best_dist = d;
                if (best_len == MAX_MATCH)
                    break;
            end
        end
        if (best_len >= MIN_MATCH)
        begin
            t.kind     = lzmf_pkg::TOKEN_MATCH;
            t.lit      = '0;
            t.len      = best_len[lzmf_pkg::LEN_W-1:0];
            t.distance = best_dist[lzmf_pkg::DIST_W-1:0];
            bytes_coded = pos + best_len;
            if (best_len > longest_match)
                longest_match = best_len;
        end
        else
        begin
            t.kind     = lzmf_pkg::TOKEN_LITERAL;
            t.lit      = history[pos % RING_DEPTH];
            t.len      = '0;
            t.distance = '0;
            bytes_coded = pos + 1;
        end
    endtask

    task automatic lz_tokenize(input logic [lzmf_pkg::OP_W-1:0] op,
                               input logic [lzmf_pkg::BYTE_W-1:0] value);
        token_t t;
        if (op == lzmf_pkg::OP_PUSH)
        begin
            history[bytes_in % RING_DEPTH] = value;
            bytes_in++;
            if (bytes_in - bytes_coded >= MAX_MATCH)
            begin
                find_token(t);
                pending_tokens.push_back(t);
            end
        end
        else
        begin
            if (bytes_in == bytes_coded)
            begin
                t.kind     = lzmf_pkg::TOKEN_END;
                t.lit      = '0;
                t.len      = '0;
                t.distance = '0;
                bytes_in = 0;
                bytes_coded = 0;
            end
            else
                find_token(t);
            drain_kind = t.kind;
            pending_tokens.push_back(t);
        end
    endtask

    // command driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_ch.valid     <= 1'b0;
            cmd_ch.operation <= lzmf_pkg::OP_PUSH;
            cmd_ch.data_byte <= '0;
            send_gap = 0;
        end
        else
        begin
            send_valid = cmd_ch.valid;
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                lz_tokenize(cmd_ch.operation, cmd_ch.data_byte);
                items_sent++;
                send_valid = 1'b0;
                send_gap = no_idle ? 0 : $urandom_range(0, 4);
            end
            else if (!send_valid && send_gap != 0)
                send_gap--;
            if (!send_valid && send_gap == 0 && cmd_q.size() != 0)
            begin
                next_item = cmd_q.pop_front();
                cmd_ch.operation <= next_item.op;
                cmd_ch.data_byte <= next_item.data;
                send_valid = 1'b1;
            end
            cmd_ch.valid <= send_valid;
        end
    end

    // token monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_ch.ready <= 1'b0;
            recv_stall = 0;
        end
        else
        begin
            recv_ready = tok_ch.ready;
            if (tok_ch.valid && tok_ch.ready)
            begin
                if (pending_tokens.size() == 0)
                    report_mismatch($sformatf("unexpected token kind %0d", tok_ch.token_kind));
                else
                begin
                    want = pending_tokens.pop_front();
                    if (tok_ch.token_kind !== want.kind)
                        report_mismatch($sformatf("token_kind got %0d want %0d",
                                                  tok_ch.token_kind, want.kind));
                    if (tok_ch.literal_byte !== want.lit)
                        report_mismatch($sformatf("literal_byte got %0h want %0h",
                                                  tok_ch.literal_byte, want.lit));
                    if (tok_ch.match_length !== want.len)
                        report_mismatch($sformatf("match_length got %0d want %0d",
                                                  tok_ch.match_length, want.len));
                    if (tok_ch.match_distance !== want.distance)
                        report_mismatch($sformatf("match_distance got %0d want %0d",
                                                  tok_ch.match_distance, want.distance));
                    case (want.kind)
                        lzmf_pkg::TOKEN_LITERAL: lit_count++;
                        lzmf_pkg::TOKEN_MATCH:   match_count++;
                        default:                 end_count++;
                    endcase
                end
                recv_stall = no_idle ? 0 : $urandom_range(0, 4);
                recv_ready = (recv_stall == 0);
            end
            else if (!recv_ready)
            begin
                if (recv_stall != 0)
                    recv_stall--;
                if (recv_stall == 0)
                    recv_ready = 1'b1;
            end
            tok_ch.ready <= recv_ready;
        end
    end

    task automatic wait_sent();
        while (cmd_q.size() != 0 || cmd_ch.valid)
            @(negedge clk);
    endtask

    task automatic wait_idle();
        wait_sent();
        while (pending_tokens.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_window(input logic [lzmf_pkg::WINDOW_W-1:0] value);
        @(posedge clk);
        cfg_ch.valid       <= 1'b1;
        cfg_ch.window_size <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        window_reg = value;
        window_writes++;
    endtask

    task automatic push_byte(input logic [lzmf_pkg::BYTE_W-1:0] value);
        cmd_q.push_back({lzmf_pkg::OP_PUSH, value});
    endtask

    // drain one token at a time until the stream closes
    task automatic drain_stream();
        do
        begin
            cmd_q.push_back({lzmf_pkg::OP_DRAIN, lzmf_pkg::BYTE_W'($urandom)});
            wait_sent();
        end
        while (drain_kind != lzmf_pkg::TOKEN_END);
    endtask

    task automatic send_stream(input int unsigned len, input int unsigned style,
                               input bit broken);
        logic [lzmf_pkg::BYTE_W-1:0] pat [8];
        logic [lzmf_pkg::BYTE_W-1:0] b;
        int unsigned                 period;
        b = $urandom;
        period = $urandom_range(1, 8);
        foreach (pat[j])
            pat[j] = $urandom;
        for (int unsigned i = 0; i < len; i++)
        begin
            case (style)
                0: b = $urandom;
                1: b = pat[$urandom_range(0, 3)];
                2: b = ($urandom_range(0, 15) == 0) ? pat[$urandom_range(0, 7)]
                                                    : pat[i % period];
                default: b = ($urandom_range(0, 3) == 0) ? pat[$urandom_range(0, 7)] : b;
            endcase
            push_byte(b);
            if (broken && $urandom_range(0, 7) == 0)
                cmd_q.push_back({lzmf_pkg::OP_DRAIN, lzmf_pkg::BYTE_W'($urandom)});
        end
        drain_stream();
    endtask

    task automatic random_phase(input logic [lzmf_pkg::WINDOW_W-1:0] win,
                                input int unsigned streams, input int unsigned max_len);
        write_window(win);
        no_idle = ($urandom_range(0, 3) == 0);
        for (int unsigned s = 0; s < streams; s++)
        begin
            if ($urandom_range(0, 4) == 0)
                drain_stream();
            send_stream($urandom_range(1, max_len), $urandom_range(0, 3),
                        $urandom_range(0, 3) == 0);
        end
        wait_idle();
    endtask

    initial
    begin
        #200_000_000;
        $display("tb_lz77_greedy_match_finder_core NOT OK");
        $finish;
    end

    initial
    begin
        rst_n              <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.window_size <= '0;
        bytes_in    = 0;
        bytes_coded = 0;
        window_reg  = lzmf_pkg::WINDOW_RESET;
        drain_kind  = lzmf_pkg::TOKEN_END;
        no_idle     = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (4) @(negedge clk);

        // directed: empty drain, byte extremes, overlapping match, tie on distance
        drain_stream();
        push_byte(8'hFF);
        push_byte(8'h00);
        drain_stream();
        for (int i = 0; i < 7; i++)
            push_byte((i % 2 == 0) ? 8'h01 : 8'h02);
        drain_stream();
        push_byte(8'h05); push_byte(8'h06); push_byte(8'h09); push_byte(8'h05);
        push_byte(8'h06); push_byte(8'h08); push_byte(8'h05); push_byte(8'h06);
        drain_stream();
        wait_idle();

        // window at its extremes, out of range and random
        random_phase(13'd1, 1, 12);
        random_phase(13'd0, 1, 12);
        random_phase(13'd3, 1, 12);
        random_phase(lzmf_pkg::WINDOW_W'($urandom_range(4, 40)), 1, 16);
        random_phase(13'd8191, 1, 12);
        random_phase(lzmf_pkg::WINDOW_W'($urandom_range(4097, 8190)), 1, 12);

        // long stream: tokens on push once the lookahead is full
        write_window(lzmf_pkg::WINDOW_RESET);
        no_idle = 1'b0;
        send_stream(258, 2, 1'b0);
        wait_idle();
        random_phase(lzmf_pkg::WINDOW_W'($urandom_range(1, 300)), 1, 16);

        repeat (20) @(negedge clk);
        if (pending_tokens.size() != 0)
            report_mismatch($sformatf("%0d tokens never arrived", pending_tokens.size()));
        $display("Run: %0d items, %0d window writes; tokens %0d literal, %0d match, %0d end",
                 items_sent, window_writes, lit_count, match_count, end_count);
        $display("Longest match seen: %0d bytes", longest_match);
        if (error_count == 0)
            $display("tb_lz77_greedy_match_finder_core OK");
        else
            $display("tb_lz77_greedy_match_finder_core NOT OK");
        $finish;
    end

endmodule
